@@ design/setf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_pkg: shared types and constants for the scanline edge table fill
// Modes, controller states, and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package setf_pkg;

   localparam int COL_W = 9;
   localparam logic [COL_W-1:0] COL_MAX = 9'd511;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_EDGE  = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_WALK,
      ST_DRAIN,
      ST_QREAD,
      ST_QOUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_init;
      logic clr_step;
      logic div_start;
      logic div_take;
      logic walk_step;
      logic q_read;
      logic q_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic dy_zero;
      logic div_done;
      logic walk_last;
      logic rsp_free;
   } status_type;

endpackage

@@ design/setf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface setf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [8:0] x_start;
   logic [8:0] y_start;
   logic [8:0] x_end;
   logic [8:0] y_end;

   modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
   modport sink (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface setf_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] row;
   logic [8:0] span_left;
   logic [8:0] span_right;
   logic       filled;

   modport source (output valid, row, span_left, span_right, filled, input ready);
   modport sink (input valid, row, span_left, span_right, filled, output ready);
endinterface

@@ design/setf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_div: serial restoring divider
// One quotient bit per cycle; unsigned numerator over a nonzero 9-bit row
// difference, quotient truncated.
// ----------------------------------------------------------------------------
module setf_div #(
   parameter int NUM_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [8:0]       den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [9:0]       rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [8:0]       den_ff, den_in;
   logic [9:0]       rem_sh;
   logic             fits;
   logic             last;

   assign rem_sh = {rem_ff[8:0], quo_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};
   assign last   = cnt_ff == CNT_W'(NUM_W - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider not busy after start");

endmodule

@@ design/setf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_ctrl: sequencing controller
// Runs the clear sweep, the slope division and row walk of an edge, and the
// two-step row query.
// ----------------------------------------------------------------------------
module setf_ctrl
   import setf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_EDGE:  state_in = ST_SETUP;
                  MODE_QUERY: state_in = ST_QREAD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: state_in = status.dy_zero ? ST_IDLE : ST_DIV;
         ST_DIV:   if (status.div_done) state_in = ST_WALK;
         ST_WALK:  if (status.walk_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_IDLE;
         ST_QREAD: state_in = ST_QOUT;
         ST_QOUT:  if (status.rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.accept   = req_valid;
            cmd.clr_init = req_valid && (req_mode == MODE_CLEAR);
         end
         ST_SETUP: cmd.div_start = !status.dy_zero;
         ST_DIV:   cmd.div_take = status.div_done;
         ST_WALK:  cmd.walk_step = 1'b1;
         ST_QREAD: cmd.q_read = 1'b1;
         ST_QOUT:  cmd.q_load = status.rsp_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_edge_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_mode == MODE_EDGE |=> state_ff == ST_SETUP)
      else $error("edge request did not enter setup");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.q_load |-> status.rsp_free)
      else $error("response loaded over a pending one");

endmodule

@@ design/setf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_datapath: edge tables, row walker and response register
// Left/right bound memories with registered reads, a one-deep read-modify-
// write stage for the edge walk, the slope divider and the response register.
// ----------------------------------------------------------------------------
module setf_datapath
   import setf_pkg::*;
#(
   parameter int ROWS      = 512,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [1:0] req_mode,
   input  logic [8:0] req_x_start,
   input  logic [8:0] req_y_start,
   input  logic [8:0] req_x_end,
   input  logic [8:0] req_y_end,
   setf_rsp_if.source rsp
);

   localparam int RW    = $clog2(ROWS);
   localparam int NUM_W = COL_W + FRAC_BITS;
   localparam int XW    = NUM_W + 2;

   logic [COL_W-1:0] left_mem  [ROWS];
   logic [COL_W-1:0] right_mem [ROWS];

   logic             swap, neg;
   logic [8:0]       ya, xa, xb, dy, mag;

   logic [8:0]          row_ff, row_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] slope_ff, slope_in;
   logic [8:0]          walk_cnt_ff, walk_cnt_in;
   logic [8:0]          dy_ff, dy_in;
   logic [8:0]          mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [RW-1:0]       clr_cnt_ff, clr_cnt_in;

   logic                pend_ff, pend_in;
   logic [RW-1:0]       pend_row_ff, pend_row_in;
   logic [COL_W-1:0]    pend_col_ff, pend_col_in;

   logic [COL_W-1:0]    lrd_ff, rrd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [8:0]          rsp_row_ff;
   logic [COL_W-1:0]    rsp_left_ff, rsp_right_ff;
   logic                rsp_filled_ff;

   logic                row_ok;
   logic                rd_en, wr_en;
   logic [RW-1:0]       rd_addr, wr_addr;
   logic [COL_W-1:0]    wr_left, wr_right;
   logic                x_pos;
   logic [XW-FRAC_BITS-1:0] x_int;
   logic [COL_W-1:0]    col;
   logic [COL_W-1:0]    q_left, q_right;
   logic                div_done;
   logic [NUM_W-1:0]    quo;
   logic [XW-1:0]       quo_ext;

   // order endpoints by row
   assign swap = req_y_end < req_y_start;
   assign ya   = swap ? req_y_end : req_y_start;
   assign xa   = swap ? req_x_end : req_x_start;
   assign xb   = swap ? req_x_start : req_x_end;
   assign dy   = swap ? (req_y_start - req_y_end) : (req_y_end - req_y_start);
   assign neg  = xb < xa;
   assign mag  = neg ? (xa - xb) : (xb - xa);

   setf_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({mag_ff, {FRAC_BITS{1'b0}}}),
      .den   (dy_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign quo_ext = {{(XW-NUM_W){1'b0}}, quo};
   assign row_ok  = 32'(row_ff) < 32'(ROWS);

   // integer part of x, clamped to the column range
   assign x_pos = !x_ff[XW-1] && (x_ff != '0);
   assign x_int = x_ff[XW-1:FRAC_BITS];
   assign col   = !x_pos ? '0 :
                  (x_int[XW-FRAC_BITS-1:COL_W] != '0) ? COL_MAX : x_int[COL_W-1:0];

   always_comb begin
      row_in      = row_ff;
      x_in        = x_ff;
      slope_in    = slope_ff;
      walk_cnt_in = walk_cnt_ff;
      dy_in       = dy_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (cmd.accept) begin
         row_in      = (req_mode == MODE_QUERY) ? req_y_start : ya;
         x_in        = XW'({xa, {FRAC_BITS{1'b0}}});
         walk_cnt_in = dy;
         dy_in       = dy;
         mag_in      = mag;
         neg_in      = neg;
      end
      if (cmd.clr_init) clr_cnt_in = '0;
      if (cmd.clr_step) clr_cnt_in = clr_cnt_ff + RW'(1);
      if (cmd.div_take) slope_in = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);
      if (cmd.walk_step) begin
         row_in      = row_ff + 9'd1;
         x_in        = x_ff + slope_ff;
         walk_cnt_in = walk_cnt_ff - 9'd1;
      end
   end

   assign pend_in     = cmd.walk_step && row_ok;
   assign pend_row_in = RW'(row_ff);
   assign pend_col_in = col;

   assign rd_en   = (cmd.walk_step || cmd.q_read) && row_ok;
   assign rd_addr = RW'(row_ff);
   assign wr_en   = cmd.clr_step || pend_ff;
   assign wr_addr = cmd.clr_step ? clr_cnt_ff : pend_row_ff;
   assign wr_left  = cmd.clr_step ? COL_MAX :
                     ((pend_col_ff < lrd_ff) ? pend_col_ff : lrd_ff);
   assign wr_right = cmd.clr_step ? '0 :
                     ((pend_col_ff > rrd_ff) ? pend_col_ff : rrd_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
      if (rd_en) begin
         lrd_ff <= left_mem[rd_addr];
         rrd_ff <= right_mem[rd_addr];
      end
   end

   assign q_left       = row_ok ? lrd_ff : COL_MAX;
   assign q_right      = row_ok ? rrd_ff : '0;
   assign rsp_valid_in = cmd.q_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      x_ff        <= x_in;
      slope_ff    <= slope_in;
      walk_cnt_ff <= walk_cnt_in;
      dy_ff       <= dy_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      if (cmd.q_load) begin
         rsp_row_ff    <= row_ff;
         rsp_left_ff   <= q_left;
         rsp_right_ff  <= q_right;
         rsp_filled_ff <= q_left <= q_right;
      end
   end

   assign status.clr_last  = clr_cnt_ff == RW'(ROWS - 1);
   assign status.dy_zero   = dy_ff == '0;
   assign status.div_done  = div_done;
   assign status.walk_last = walk_cnt_ff == 9'd1;
   assign status.rsp_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.row        = rsp_row_ff;
   assign rsp.span_left  = rsp_left_ff;
   assign rsp.span_right = rsp_right_ff;
   assign rsp.filled     = rsp_filled_ff;

   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !x_ff[XW-1])
      else $error("edge x went negative during walk");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.q_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_no_clear_rmw: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !pend_ff)
      else $error("clear sweep collides with edge update");

endmodule

@@ design/scanline_edge_table_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_edge_table_fill: scanline fill engine with per-row edge tables
// Clears the left/right bound tables, rasterizes edges into them with a
// fixed-point slope, and reports the span of a requested row.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   when it moves
//  req       in   mode, x_start, y_start, x_end, y_end      valid && ready
//  rsp       out  row, span_left, span_right, filled        valid && ready
//
//  Clear: one table row written per cycle, every row in turn.
//  Edge: serial divider, then one row per cycle through a read-modify-write
//  stage; a horizontal edge (no row difference) writes no rows.
//  Query: a table read, then a load of the output register; a waiting response
//  stalls the next query, which holds req.ready low; other requests are taken.
//  After reset every table row is swept before req.ready rises.
// ----------------------------------------------------------------------------
module scanline_edge_table_fill
   import setf_pkg::*;
#(
   parameter int ROWS      = 512,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   setf_req_if.sink   req,
   setf_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req.ready = req_ready;

   setf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   setf_datapath #(
      .ROWS      (ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_mode    (req.mode),
      .req_x_start (req.x_start),
      .req_y_start (req.y_start),
      .req_x_end   (req.x_end),
      .req_y_end   (req.y_end),
      .rsp         (rsp)
   );

endmodule
